// File: hdl/aca_pkg.sv
package aca_pkg;

    localparam int MAX_SYMBOLS_DEF = 64;
    localparam int RESET_LETTERS   = 26;
    localparam int FIRST_LETTER    = 65;

    localparam logic OP_LOAD   = 1'b0;
    localparam logic OP_CIPHER = 1'b1;

    localparam logic [1:0] ST_OK   = 2'd0;
    localparam logic [1:0] ST_KEYA = 2'd1;
    localparam logic [1:0] ST_KEYB = 2'd2;

    localparam logic [1:0] CFG_MODULUS = 2'd0;
    localparam logic [1:0] CFG_KEY_A   = 2'd1;
    localparam logic [1:0] CFG_KEY_B   = 2'd2;
    localparam logic [1:0] CFG_DECRYPT = 2'd3;

    typedef struct packed {
        logic       v;
        logic       cip;
        logic [1:0] st;
    } t_side;

    function automatic logic [7:0] reset_entry(input int i);
        logic [7:0] r;
        r = 8'd0;
        if (i < RESET_LETTERS) begin
            r = 8'(FIRST_LETTER + i);
        end
        return r;
    endfunction

endpackage

// File: hdl/aca_keyunit.sv
module aca_keyunit import aca_pkg::*; #(
    parameter int MAX_SYMBOLS = MAX_SYMBOLS_DEF,
    parameter int IW = $clog2(MAX_SYMBOLS + 1)
) (
    input  logic          i_clk,
    input  logic          i_rst_n,
    input  logic          i_wr,
    input  logic [1:0]    i_idx,
    input  logic [7:0]    i_data,
    output logic          o_busy,
    output logic [IW-1:0] o_n,
    output logic [7:0]    o_kb,
    output logic          o_dec,
    output logic [IW-1:0] o_ar,
    output logic [IW-1:0] o_inv,
    output logic          o_cop
);

    localparam logic [1:0] S_IDLE = 2'd0;
    localparam logic [1:0] S_RED  = 2'd1;
    localparam logic [1:0] S_SRCH = 2'd2;

    logic [1:0]    r_state;
    logic [6:0]    r_mod;
    logic [7:0]    r_ka;
    logic [7:0]    r_kb;
    logic          r_dec;
    logic [7:0]    r_ar;
    logic [IW:0]   r_acc;
    logic [IW-1:0] r_k;
    logic [IW-1:0] r_inv;
    logic          r_cop;
    logic [IW-1:0] w_n;
    logic [IW:0]   n_acc;

    always_comb begin
        if (int'(r_mod) < 2) begin
            w_n = IW'(2);
        end else if (int'(r_mod) > MAX_SYMBOLS) begin
            w_n = IW'(MAX_SYMBOLS);
        end else begin
            w_n = IW'(r_mod);
        end
        n_acc = r_acc + (IW+1)'(r_ar);
        if (n_acc >= (IW+1)'(w_n)) begin
            n_acc = n_acc - (IW+1)'(w_n);
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_IDLE;
            r_mod   <= 7'd26;
            r_ka    <= 8'd1;
            r_kb    <= 8'd0;
            r_dec   <= 1'b0;
            r_ar    <= 8'd1;
            r_inv   <= IW'(1);
            r_cop   <= 1'b1;
            r_acc   <= '0;
            r_k     <= '0;
        end else begin
            case (r_state)
                S_IDLE: begin
                    if (i_wr) begin
                        case (i_idx)
                            CFG_MODULUS: r_mod <= i_data[6:0];
                            CFG_KEY_A:   r_ka  <= i_data;
                            CFG_KEY_B:   r_kb  <= i_data;
                            CFG_DECRYPT: r_dec <= i_data[0];
                            default: ;
                        endcase
                        r_ar    <= (i_idx == CFG_KEY_A) ? i_data : r_ka;
                        r_state <= S_RED;
                    end
                end
                S_RED: begin
                    if (int'(r_ar) >= int'(w_n)) begin
                        r_ar <= r_ar - 8'(w_n);
                    end else begin
                        r_acc   <= (IW+1)'(r_ar);
                        r_k     <= IW'(1);
                        r_state <= S_SRCH;
                    end
                end
                S_SRCH: begin
                    if (r_acc == (IW+1)'(1)) begin
                        r_inv   <= r_k;
                        r_cop   <= 1'b1;
                        r_state <= S_IDLE;
                    end else if (r_k == w_n - IW'(1)) begin
                        r_inv   <= IW'(1);
                        r_cop   <= 1'b0;
                        r_state <= S_IDLE;
                    end else begin
                        r_acc <= n_acc;
                        r_k   <= r_k + IW'(1);
                    end
                end
                default: r_state <= S_IDLE;
            endcase
        end
    end

    assign o_busy = (r_state != S_IDLE);
    assign o_n    = w_n;
    assign o_kb   = r_kb;
    assign o_dec  = r_dec;
    assign o_ar   = IW'(r_ar);
    assign o_inv  = r_inv;
    assign o_cop  = r_cop;

endmodule

// File: hdl/aca_modred.sv
module aca_modred import aca_pkg::*; #(
    parameter int IW = 7,
    parameter int PW = 2 * IW
) (
    input  logic          i_clk,
    input  logic          i_rst_n,
    input  logic          i_en,
    input  logic [IW-1:0] i_n,
    input  logic [PW-1:0] i_p,
    input  t_side         i_sd,
    output logic [IW-1:0] o_rem,
    output t_side         o_sd,
    output logic          o_busy
);

    // restoring reduction, 4 shift-subtract steps per stage
    localparam int NS   = PW - 1;
    localparam int NSTG = (NS + 3) / 4;
    localparam int WW   = PW + IW;

    logic [PW-1:0] r_p  [NSTG];
    t_side         r_sd [NSTG];
    logic [NSTG-1:0] w_cip;

    genvar s;
    generate
        for (s = 0; s < NSTG; s++) begin : g_stg
            logic [WW-1:0] w_val;
            logic [PW-1:0] w_src_p;
            t_side         w_src_sd;
            if (s == 0) begin : g_first
                assign w_src_p  = i_p;
                assign w_src_sd = i_sd;
            end else begin : g_next
                assign w_src_p  = r_p[s-1];
                assign w_src_sd = r_sd[s-1];
            end
            always_comb begin
                int k;
                logic [WW-1:0] sub;
                w_val = WW'(w_src_p);
                for (int t = 0; t < 4; t++) begin
                    k = NS - 1 - (s * 4 + t);
                    if (k >= 0) begin
                        sub = WW'(i_n) << k;
                        if (w_val >= sub) begin
                            w_val = w_val - sub;
                        end
                    end
                end
            end
            always_ff @(posedge i_clk) begin
                if (!i_rst_n) begin
                    r_sd[s] <= '0;
                end else if (i_en) begin
                    r_sd[s] <= w_src_sd;
                end
            end
            always_ff @(posedge i_clk) begin
                if (i_en) begin
                    r_p[s] <= PW'(w_val);
                end
            end
            assign w_cip[s] = r_sd[s].v & r_sd[s].cip;
        end
    endgenerate

    assign o_rem  = IW'(r_p[NSTG-1]);
    assign o_sd   = r_sd[NSTG-1];
    assign o_busy = |w_cip;

endmodule

// File: hdl/affine_cipher_alphabet.sv
// Affine cipher over a loadable alphabet of up to MAX_SYMBOLS codes.
// Input stream: s tuser = operation (0 load, 1 cipher); s tdata holds
// entry_index and char_code. Every input beat yields one output beat:
// m tdata holds out_char and out_position, m tuser holds status.
// Config channel: index 0 modulus, 1 key_a, 2 key_b, 3 decrypt_mode.
// Each write starts a key setup sequencer that reduces key_a mod n and
// searches its inverse one candidate per cycle; both channels hold ready
// low while it runs.
// Throughput: one beat per cycle while the receiver takes beats, no key
// setup runs and no load beat waits. A beat passes the input register,
// the compare and product registers, the modular reducer stages (4 steps
// each) and the output register with the table read.
// A load beat waits while a cipher beat is still ahead of the table read.
// Reset loads A..Z into the first 26 entries, modulus 26, key_a 1,
// key_b 0, encrypt mode, and empties the pipeline.
// A stalled receiver freezes the whole pipeline; nothing is lost.
module affine_cipher_alphabet import aca_pkg::*; #(
    parameter int MAX_SYMBOLS = MAX_SYMBOLS_DEF
) (
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        i_s_tvalid,
    output logic        o_s_tready,
    input  logic [15:0] i_s_tdata,   // entry_index[5:0], char_code[13:6], zero
    input  logic        i_s_tuser,   // operation
    output logic        o_m_tvalid,
    input  logic        i_m_tready,
    output logic [15:0] o_m_tdata,   // out_char[7:0], out_position[14:8], zero
    output logic [1:0]  o_m_tuser,   // status
    input  logic        i_cfg_valid,
    output logic        o_cfg_ready,
    input  logic [1:0]  i_cfg_index,
    input  logic [7:0]  i_cfg_data
);

    localparam int IW = $clog2(MAX_SYMBOLS + 1);
    localparam int AW = (MAX_SYMBOLS > 1) ? $clog2(MAX_SYMBOLS) : 1;
    localparam int PW = 2 * IW;

    logic          w_kbusy;
    logic [IW-1:0] w_n, w_ar, w_inv;
    logic [7:0]    w_kb;
    logic          w_dec, w_cop;

    aca_keyunit #(.MAX_SYMBOLS(MAX_SYMBOLS), .IW(IW)) u_key (
        .i_clk  (i_clk),
        .i_rst_n(i_rst_n),
        .i_wr   (i_cfg_valid & o_cfg_ready),
        .i_idx  (i_cfg_index),
        .i_data (i_cfg_data),
        .o_busy (w_kbusy),
        .o_n    (w_n),
        .o_kb   (w_kb),
        .o_dec  (w_dec),
        .o_ar   (w_ar),
        .o_inv  (w_inv),
        .o_cop  (w_cop)
    );

    logic          w_en, w_acc, w_hz, w_mrbusy;
    logic [5:0]    w_idx;
    logic [7:0]    w_ch;
    logic [AW-1:0] w_widx;
    logic          w_wr;
    logic [1:0]    w_st;

    assign w_idx  = i_s_tdata[5:0];
    assign w_ch   = i_s_tdata[13:6];
    assign w_widx = AW'(w_idx);
    assign w_en   = ~o_m_tvalid | i_m_tready;

    t_side         r_a_sd, r_b_sd, r_c_sd, r_o_sd, w_m_sd;
    logic [7:0]    r_a_ch;
    logic [IW-1:0] r_b_x;
    logic [PW-1:0] r_c_p;
    logic [IW-1:0] w_rem, w_j, r_o_j;

    assign w_hz = (r_a_sd.v & r_a_sd.cip) | (r_b_sd.v & r_b_sd.cip)
                | (r_c_sd.v & r_c_sd.cip) | w_mrbusy;
    assign o_s_tready  = w_en & ~w_kbusy & ~((i_s_tuser == OP_LOAD) & w_hz);
    assign o_cfg_ready = ~w_kbusy;
    assign w_acc = i_s_tvalid & o_s_tready;
    assign w_wr  = w_acc & (i_s_tuser == OP_LOAD) & (int'(w_idx) < MAX_SYMBOLS);

    always_comb begin
        if (!w_cop) begin
            w_st = ST_KEYA;
        end else if (int'(w_kb) >= int'(w_n)) begin
            w_st = ST_KEYB;
        end else begin
            w_st = ST_OK;
        end
    end

    // search table, flops with parallel compare
    logic [7:0] r_tab [MAX_SYMBOLS];
    logic [IW-1:0] w_x;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            for (int i = 0; i < MAX_SYMBOLS; i++) begin
                r_tab[i] <= reset_entry(i);
            end
        end else if (w_wr) begin
            r_tab[w_widx] <= w_ch;
        end
    end

    always_comb begin
        w_x = '0;
        for (int i = MAX_SYMBOLS - 1; i >= 0; i--) begin
            if ((i < int'(w_n)) && (r_tab[i] == r_a_ch)) begin
                w_x = IW'(i + 1);
            end
        end
    end

    // stage products
    logic [IW-1:0] w_d;
    logic [PW-1:0] w_p;

    always_comb begin
        if (r_b_x >= IW'(w_kb)) begin
            w_d = r_b_x - IW'(w_kb);
        end else begin
            w_d = r_b_x + w_n - IW'(w_kb);
        end
        if (w_dec) begin
            w_p = PW'(w_d) * PW'(w_inv);
        end else begin
            w_p = PW'(w_ar) * PW'(r_b_x) + PW'(IW'(w_kb));
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_a_sd <= '0;
            r_b_sd <= '0;
            r_c_sd <= '0;
        end else if (w_en) begin
            r_a_sd.v   <= w_acc;
            r_a_sd.cip <= (i_s_tuser == OP_CIPHER);
            r_a_sd.st  <= (i_s_tuser == OP_CIPHER) ? w_st : ST_OK;
            r_b_sd     <= r_a_sd;
            r_c_sd     <= r_b_sd;
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_en) begin
            r_a_ch <= w_ch;
            r_b_x  <= w_x;
            r_c_p  <= w_p;
        end
    end

    aca_modred #(.IW(IW), .PW(PW)) u_mod (
        .i_clk  (i_clk),
        .i_rst_n(i_rst_n),
        .i_en   (w_en),
        .i_n    (w_n),
        .i_p    (r_c_p),
        .i_sd   (r_c_sd),
        .o_rem  (w_rem),
        .o_sd   (w_m_sd),
        .o_busy (w_mrbusy)
    );

    assign w_j = (w_rem == '0) ? w_n : w_rem;

    // output copy of the table, valid bits stand in for the reset image
    logic [7:0]       r_mem [MAX_SYMBOLS];
    logic [MAX_SYMBOLS-1:0] r_mv;
    logic [AW-1:0]    w_raddr;
    logic [7:0]       r_rd, r_rdef;
    logic             r_rmv;

    assign w_raddr = AW'(w_j - IW'(1));

    always_ff @(posedge i_clk) begin
        if (w_wr) begin
            r_mem[w_widx] <= w_ch;
        end
        if (w_en) begin
            r_rd <= r_mem[w_raddr];
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_mv <= '0;
        end else if (w_wr) begin
            r_mv[w_widx] <= 1'b1;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_o_sd <= '0;
        end else if (w_en) begin
            r_o_sd <= w_m_sd;
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_en) begin
            r_o_j  <= w_j;
            r_rmv  <= r_mv[w_raddr];
            r_rdef <= reset_entry(int'(w_raddr));
        end
    end

    logic       w_ok;
    logic [7:0] w_char;

    assign w_ok   = r_o_sd.cip & (r_o_sd.st == ST_OK);
    assign w_char = w_ok ? (r_rmv ? r_rd : r_rdef) : 8'd0;

    assign o_m_tvalid = r_o_sd.v;
    assign o_m_tdata  = {1'b0, (w_ok ? 7'(r_o_j) : 7'd0), w_char};
    assign o_m_tuser  = r_o_sd.st;

endmodule

// File: hdl/aca_checker.sv
module aca_checker import aca_pkg::*; (
    input logic        i_clk,
    input logic        i_rst_n,
    input logic        o_m_tvalid,
    input logic        i_m_tready,
    input logic [15:0] o_m_tdata,
    input logic [1:0]  o_m_tuser
);

    a_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_m_tvalid && !i_m_tready |=> o_m_tvalid && $stable(o_m_tdata))
        else $error("output beat dropped under stall");

    a_err_zero: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_m_tvalid && (o_m_tuser != ST_OK) |-> o_m_tdata == 16'd0)
        else $error("error beat carries data");

    a_char_pos: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_m_tvalid && (o_m_tdata[14:8] == 7'd0) |-> o_m_tdata[7:0] == 8'd0)
        else $error("character without position");

    a_rst: assert property (@(posedge i_clk)
        $past(!i_rst_n) |-> !o_m_tvalid)
        else $error("output valid after reset");

endmodule

bind affine_cipher_alphabet aca_checker u_aca_checker (
    .i_clk     (i_clk),
    .i_rst_n   (i_rst_n),
    .o_m_tvalid(o_m_tvalid),
    .i_m_tready(i_m_tready),
    .o_m_tdata (o_m_tdata),
    .o_m_tuser (o_m_tuser)
);

// File: bench/tb_top.sv
`default_nettype none

module tb_top;
    import aca_pkg::*;

    timeunit 1ns;
    timeprecision 1ps;

    localparam int NSYM = 64;
    localparam int RAND_ITEMS = 1650;
    localparam int STALL_LIMIT = 20000;

    typedef struct packed {
        logic       op;
        logic [5:0] idx;
        logic [7:0] ch;
    } t_char_beat;

    typedef struct packed {
        logic [7:0] out_char;
        logic [6:0] pos;
        logic [1:0] st;
    } t_cipher_res;

    logic        i_clk;
    logic        i_rst_n;
    logic        i_s_tvalid;
    logic        o_s_tready;
    logic [15:0] i_s_tdata;
    logic        i_s_tuser;
    logic        o_m_tvalid;
    logic        i_m_tready;
    logic [15:0] o_m_tdata;
    logic [1:0]  o_m_tuser;
    logic        i_cfg_valid;
    logic        o_cfg_ready;
    logic [1:0]  i_cfg_index;
    logic [7:0]  i_cfg_data;

    affine_cipher_alphabet dut (.*);

    // predictor state
    logic [7:0] alpha_tbl [NSYM];
    logic [6:0] mdl_mod;
    logic [7:0] mdl_ka;
    logic [7:0] mdl_kb;
    logic       mdl_dec;

    t_char_beat  char_q [$];
    t_cipher_res cipher_exp_q [$];
    int  mismatches;
    int  idle_cycles;
    bit  quiet_tail;
    bit  hold_rx;
    bit  in_taken;
    int  tx_gap;
    int  rx_gap;

    function automatic int gcd_of(int x, int y);
        int t;
        while (y != 0) begin
            t = x % y;
            x = y;
            y = t;
        end
        return x;
    endfunction

    function automatic t_cipher_res cipher_predict(t_char_beat b);
        t_cipher_res r;
        int n, x, j, d, inv;
        r = '0;
        if (b.op == OP_LOAD) begin
            alpha_tbl[b.idx] = b.ch;
            return r;
        end
        n = mdl_mod;
        if (n < 2) n = 2;
        if (n > NSYM) n = NSYM;
        if (gcd_of(mdl_ka, n) != 1) begin
            r.st = ST_KEYA;
            return r;
        end
        if (mdl_kb >= n) begin
            r.st = ST_KEYB;
            return r;
        end
        x = 0;
        for (int i = 0; i < n; i++) begin
            if (x == 0 && alpha_tbl[i] == b.ch) x = i + 1;
        end
        if (!mdl_dec) begin
            j = (mdl_ka * x + mdl_kb) % n;
        end else begin
            d = (x + n - mdl_kb) % n;
            inv = 1;
            for (int k = n - 1; k >= 1; k--) begin
                if (((mdl_ka % n) * k) % n == 1) inv = k;
            end
            j = (d * inv) % n;
        end
        if (j == 0) j = n;
        r.out_char = alpha_tbl[(j - 1) % NSYM];
        r.pos = 7'(j);
        r.st = ST_OK;
        return r;
    endfunction

    always begin
        i_clk = 1'b1;
        #5;
        i_clk = 1'b0;
        #5;
    end

    always @(posedge i_clk) begin
        in_taken <= i_s_tvalid && o_s_tready;
    end

    // driver
    always @(negedge i_clk) begin
        if (in_taken) begin
            void'(char_q.pop_front());
        end
        if (tx_gap > 0) begin
            tx_gap <= tx_gap - 1;
            i_s_tvalid <= 1'b0;
        end else if (char_q.size() > 0 && !quiet_tail && !(i_s_tvalid && !in_taken)
                && $urandom_range(0, 19) == 0) begin
            tx_gap <= $urandom_range(1, 18);
            i_s_tvalid <= 1'b0;
        end else if (char_q.size() > 0) begin
            i_s_tvalid <= 1'b1;
            i_s_tdata <= {2'b00, char_q[0].ch, char_q[0].idx};
            i_s_tuser <= char_q[0].op;
        end else begin
            i_s_tvalid <= 1'b0;
        end
        if (hold_rx) begin
            i_m_tready <= 1'b0;
        end else if (rx_gap > 0) begin
            rx_gap <= rx_gap - 1;
            i_m_tready <= 1'b0;
        end else if (!quiet_tail && $urandom_range(0, 19) == 0) begin
            rx_gap <= $urandom_range(1, 18);
            i_m_tready <= 1'b0;
        end else begin
            i_m_tready <= 1'b1;
        end
    end

    // monitor
    always @(posedge i_clk) begin
        t_cipher_res got, want;
        if (i_rst_n) begin
            if ((i_s_tvalid && o_s_tready) || (o_m_tvalid && i_m_tready)
                    || (i_cfg_valid && o_cfg_ready)) begin
                idle_cycles <= 0;
            end else begin
                idle_cycles <= idle_cycles + 1;
            end
            if (i_s_tvalid && o_s_tready) begin
                cipher_exp_q.push_back(cipher_predict(t_char_beat'{i_s_tuser,
                    i_s_tdata[5:0], i_s_tdata[13:6]}));
            end
            if (o_m_tvalid && i_m_tready) begin
                got = '{o_m_tdata[7:0], o_m_tdata[14:8], o_m_tuser};
                if (cipher_exp_q.size() == 0) begin
                    mismatches <= mismatches + 1;
                    if (mismatches < 10) $display("unexpected beat %p", got);
                end else begin
                    want = cipher_exp_q.pop_front();
                    if (got.out_char !== want.out_char || got.pos !== want.pos
                            || got.st !== want.st) begin
                        mismatches <= mismatches + 1;
                        if (mismatches < 10) begin
                            $display("mismatch: exp %p got %p", want, got);
                        end
                    end
                end
            end
        end
    end

    always @(posedge i_clk) begin
        if (idle_cycles >= STALL_LIMIT) begin
            $display("watchdog: no beat for %0d cycles", idle_cycles);
            $display("== FAIL ==");
            $finish;
        end
    end

    task automatic wait_drain();
        while (char_q.size() > 0 || cipher_exp_q.size() > 0) @(posedge i_clk);
        repeat (20) @(posedge i_clk);
    endtask

    task automatic reg_write(logic [1:0] ri, logic [7:0] val);
        @(negedge i_clk);
        i_cfg_valid <= 1'b1;
        i_cfg_index <= ri;
        i_cfg_data <= val;
        while (!o_cfg_ready) @(negedge i_clk);
        @(posedge i_clk);
        case (ri)
            CFG_MODULUS: mdl_mod = val[6:0];
            CFG_KEY_A:   mdl_ka = val;
            CFG_KEY_B:   mdl_kb = val;
            default:     mdl_dec = val[0];
        endcase
        @(negedge i_clk);
        i_cfg_valid <= 1'b0;
    endtask

    task automatic push_beat(logic op, logic [5:0] idx, logic [7:0] ch);
        char_q.push_back('{op, idx, ch});
    endtask

    // mostly valid keys, sometimes broken ones
    task automatic pick_keys();
        int n;
        reg_write(CFG_MODULUS, 8'($urandom_range(0, 4) == 0 ?
            $urandom_range(0, 127) : $urandom_range(2, 40)));
        n = mdl_mod < 2 ? 2 : (mdl_mod > NSYM ? NSYM : mdl_mod);
        if ($urandom_range(0, 5) == 0) begin
            reg_write(CFG_KEY_A, 8'($urandom_range(0, 255)));
        end else begin
            do mdl_ka = 8'($urandom_range(1, 255)); while (gcd_of(mdl_ka, n) != 1);
            reg_write(CFG_KEY_A, mdl_ka);
        end
        reg_write(CFG_KEY_B, 8'($urandom_range(0, 6) == 0 ?
            $urandom_range(0, 255) : $urandom_range(0, n - 1)));
        reg_write(CFG_DECRYPT, 8'($urandom_range(0, 1)));
    endtask

    initial begin
        int n;
        for (int i = 0; i < NSYM; i++) alpha_tbl[i] = reset_entry(i);
        mdl_mod = 7'd26;
        mdl_ka = 8'd1;
        mdl_kb = 8'd0;
        mdl_dec = 1'b0;
        mismatches = 0;
        idle_cycles = 0;
        quiet_tail = 0;
        hold_rx = 0;
        in_taken = 0;
        tx_gap = 0;
        rx_gap = 0;
        i_rst_n = 1'b0;
        i_s_tvalid = 1'b0;
        i_s_tdata = '0;
        i_s_tuser = OP_LOAD;
        i_m_tready = 1'b0;
        i_cfg_valid = 1'b0;
        i_cfg_index = CFG_MODULUS;
        i_cfg_data = '0;
        repeat (6) @(posedge i_clk);
        @(negedge i_clk);
        i_rst_n <= 1'b1;

        // directed: reset alphabet, identity key
        push_beat(OP_CIPHER, 6'd0, 8'h41);
        push_beat(OP_CIPHER, 6'd63, 8'h5A);
        push_beat(OP_CIPHER, 6'd0, 8'hFF);
        push_beat(OP_CIPHER, 6'd0, 8'h00);
        push_beat(OP_LOAD, 6'd63, 8'hFF);
        push_beat(OP_LOAD, 6'd26, 8'h61);
        wait_drain();
        reg_write(CFG_MODULUS, 8'd64);
        reg_write(CFG_KEY_A, 8'd255);
        reg_write(CFG_KEY_B, 8'd63);
        push_beat(OP_CIPHER, 6'd0, 8'hFF);
        push_beat(OP_CIPHER, 6'd0, 8'h00);
        push_beat(OP_CIPHER, 6'd0, 8'h61);
        wait_drain();
        reg_write(CFG_DECRYPT, 8'd1);
        push_beat(OP_CIPHER, 6'd0, 8'h41);
        push_beat(OP_CIPHER, 6'd0, 8'hFF);
        wait_drain();
        reg_write(CFG_KEY_A, 8'd0);
        push_beat(OP_CIPHER, 6'd0, 8'h41);
        wait_drain();
        reg_write(CFG_KEY_A, 8'd1);
        reg_write(CFG_KEY_B, 8'd64);
        push_beat(OP_CIPHER, 6'd0, 8'h41);
        wait_drain();
        reg_write(CFG_MODULUS, 8'd0);
        reg_write(CFG_KEY_B, 8'd1);
        push_beat(OP_CIPHER, 6'd0, 8'h41);
        wait_drain();
        reg_write(CFG_MODULUS, 8'd127);
        reg_write(CFG_KEY_B, 8'd0);
        push_beat(OP_CIPHER, 6'd0, 8'h00);
        wait_drain();

        // long receiver hold while the sender keeps offering
        hold_rx = 1;
        for (int i = 0; i < 40; i++) push_beat(1'($urandom), 6'($urandom), 8'($urandom));
        repeat (300) @(posedge i_clk);
        hold_rx = 0;
        wait_drain();

        for (int ph = 0; ph < 15; ph++) begin
            pick_keys();
            if (ph == 14) quiet_tail = 1;
            n = mdl_mod < 2 ? 2 : (mdl_mod > NSYM ? NSYM : mdl_mod);
            for (int i = 0; i < RAND_ITEMS / 15; i++) begin
                case ($urandom_range(0, 9))
                    0: push_beat(OP_LOAD, 6'($urandom), 8'($urandom));
                    1: push_beat(OP_CIPHER, 6'($urandom), 8'($urandom));
                    default: push_beat(OP_CIPHER, 6'($urandom),
                        alpha_tbl[$urandom_range(0, n - 1)] | 8'(0));
                endcase
            end
            wait_drain();
        end

        if (mismatches == 0 && cipher_exp_q.size() == 0) begin
            $display("== PASS ==");
        end else begin
            $display("== FAIL ==");
        end
        $finish;
    end

endmodule

`default_nettype wire

// File: affine_cipher_alphabet.f
hdl/aca_pkg.sv
hdl/aca_keyunit.sv
hdl/aca_modred.sv
hdl/affine_cipher_alphabet.sv
hdl/aca_checker.sv
bench/tb_top.sv
